// File: src/bhp_pkg.sv
// Package for the BMP header parser: item types, header offsets and check flags.
// Used by all modules of the parser; no dependencies.
`default_nettype none
package bhp_pkg;

	// Header length in bytes (14-byte file header plus 40-byte info header).
	localparam int unsigned HDR_LEN = 54;
	localparam int unsigned POS_W   = 6;

	// Byte offsets at which a field is complete.
	localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(1);
	localparam logic [POS_W-1:0] POS_FSIZE   = POS_W'(5);
	localparam logic [POS_W-1:0] POS_OFFBITS = POS_W'(13);
	localparam logic [POS_W-1:0] POS_INFOSZ  = POS_W'(17);
	localparam logic [POS_W-1:0] POS_WIDTH   = POS_W'(21);
	localparam logic [POS_W-1:0] POS_HEIGHT  = POS_W'(25);
	localparam logic [POS_W-1:0] POS_PLANES  = POS_W'(27);
	localparam logic [POS_W-1:0] POS_BITCNT  = POS_W'(29);
	localparam logic [POS_W-1:0] POS_COMPR   = POS_W'(33);
	localparam logic [POS_W-1:0] POS_IMGSZ   = POS_W'(37);
	localparam logic [POS_W-1:0] POS_LAST    = POS_W'(HDR_LEN - 1);
	localparam logic [POS_W-1:0] POS_DONE    = POS_W'(HDR_LEN);

	// Expected field values.
	localparam logic [15:0] BMP_TYPE_ID   = 16'h4D42;
	localparam logic [31:0] BMP_OFFBITS   = 32'd54;
	localparam logic [31:0] BMP_INFO_SIZE = 32'd40;
	localparam logic [15:0] BMP_PLANES    = 16'd1;
	localparam logic [15:0] BMP_BIT_COUNT = 16'd24;

	// Bit positions of the single-field pass flags.
	typedef enum logic [2:0] {
		CHK_TYPE    = 3'd0,
		CHK_OFFBITS = 3'd1,
		CHK_INFOSZ  = 3'd2,
		CHK_PLANES  = 3'd3,
		CHK_BITCNT  = 3'd4,
		CHK_COMPR   = 3'd5,
		CHK_IMGSZ   = 3'd6
	} chk_idx_t;
	localparam int unsigned CHK_N = 7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic               header_valid;
		logic               format_supported;
		logic signed [31:0] image_width;
		logic signed [31:0] image_height;
		logic [31:0]        row_bytes;
		logic [31:0]        file_size;
	} out_item_t;

	// Handshake status passed between the stages.
	typedef struct packed {
		logic advance;
		logic produce;
	} flow_t;

endpackage
`default_nettype wire

// File: src/bhp_in_if.sv
// Byte input channel of the BMP header parser: valid, ready and one file byte.
// Stands alone; no package needed.
`default_nettype none
interface bhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink   (input valid, input data_byte, input restart, output ready);
endinterface
`default_nettype wire

// File: src/bhp_out_if.sv
// Result channel of the BMP header parser: valid, ready and the decoded header.
// Stands alone; no package needed.
`default_nettype none
interface bhp_out_if;
	logic               valid;
	logic               ready;
	logic               header_valid;
	logic               format_supported;
	logic signed [31:0] image_width;
	logic signed [31:0] image_height;
	logic [31:0]        row_bytes;
	logic [31:0]        file_size;

	modport source (output valid, output header_valid, output format_supported,
		output image_width, output image_height, output row_bytes, output file_size,
		input ready);
	modport sink   (input valid, input header_valid, input format_supported,
		input image_width, input image_height, input row_bytes, input file_size,
		output ready);
endinterface
`default_nettype wire

// File: src/bhp_in_stage.sv
// Input register of the BMP header parser: holds one byte transfer for the capture logic.
// Depends on bhp_pkg and bhp_in_if.
`default_nettype none
module bhp_in_stage
	import bhp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	bhp_in_if.sink     in_ch,
	input  wire flow_t flow,
	output logic       item_valid_s1,
	output in_item_t   item_s1
);

	// Take a new byte when the register is empty or the held one leaves in this cycle.
	assign in_ch.ready = !item_valid_s1 || flow.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			item_valid_s1 <= in_ch.valid;
		end
	end

	// Payload register needs no reset.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.data_byte <= in_ch.data_byte;
			item_s1.restart   <= in_ch.restart;
		end
	end

endmodule
`default_nettype wire

// File: src/bhp_field_capture.sv
// Header field capture: tracks the byte offset, assembles little-endian fields,
// keeps the pass flags and forms the result at the last header byte. Depends on bhp_pkg.
`default_nettype none
module bhp_field_capture
	import bhp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid_s1,
	input  wire in_item_t item_s1,
	input  wire logic     out_free,
	output flow_t         flow,
	output out_item_t     result
);

	logic [POS_W-1:0] byte_position_q;
	logic [31:0]      field_shift_q;
	logic [CHK_N-1:0] header_checks_q;
	logic [31:0]      width_seen_q;
	logic [31:0]      height_seen_q;
	logic [31:0]      size_seen_q;

	logic [POS_W-1:0] pos;
	logic             in_header;
	logic [31:0]      shift_next;
	logic [15:0]      half_next;
	logic [CHK_N-1:0] checks_next;
	logic [31:0]      width_x3;

	// Effective offset of the held byte; a restart marks offset zero.
	assign pos        = item_s1.restart ? '0 : byte_position_q;
	assign in_header  = (pos < POS_DONE);
	assign shift_next = {item_s1.data_byte, field_shift_q[31:8]};
	assign half_next  = shift_next[31:16];

	assign flow.produce = item_valid_s1 && (pos == POS_LAST);
	assign flow.advance = item_valid_s1 && (!flow.produce || out_free);

	// Pass flags: cleared by restart, one flag updated at the end of its field.
	always_comb begin
		checks_next = item_s1.restart ? '0 : header_checks_q;
		unique case (pos)
			POS_TYPE:    checks_next[CHK_TYPE]    = (half_next == BMP_TYPE_ID);
			POS_OFFBITS: checks_next[CHK_OFFBITS] = (shift_next == BMP_OFFBITS);
			POS_INFOSZ:  checks_next[CHK_INFOSZ]  = (shift_next == BMP_INFO_SIZE);
			POS_PLANES:  checks_next[CHK_PLANES]  = (half_next == BMP_PLANES);
			POS_BITCNT:  checks_next[CHK_BITCNT]  = (half_next == BMP_BIT_COUNT);
			POS_COMPR:   checks_next[CHK_COMPR]   = (shift_next == 32'd0);
			POS_IMGSZ:   checks_next[CHK_IMGSZ]   = (shift_next != 32'd0);
			default:     ;
		endcase
	end

	// Control state: offset and pass flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			header_checks_q <= '0;
		end else if (flow.advance) begin
			if (in_header) begin
				byte_position_q <= pos + POS_W'(1);
				header_checks_q <= checks_next;
			end else begin
				byte_position_q <= POS_DONE;
				header_checks_q <= checks_next;
			end
		end
	end

	// The shift register takes each header byte; the others load where their field ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_shift_q <= '0;
			width_seen_q  <= '0;
			height_seen_q <= '0;
			size_seen_q   <= '0;
		end else if (flow.advance && in_header) begin
			field_shift_q <= shift_next;
			if (pos == POS_FSIZE) begin
				size_seen_q <= shift_next;
			end
			if (pos == POS_WIDTH) begin
				width_seen_q <= shift_next;
			end
			if (pos == POS_HEIGHT) begin
				height_seen_q <= shift_next;
			end
		end
	end

	// Result fields from the captured registers; row length is 3*width+3 rounded down to 4.
	assign width_x3 = {width_seen_q[30:0], 1'b0} + width_seen_q;

	always_comb begin
		result.header_valid     = header_checks_q[CHK_TYPE] && header_checks_q[CHK_OFFBITS];
		result.format_supported = header_checks_q[CHK_INFOSZ] && header_checks_q[CHK_PLANES]
			&& header_checks_q[CHK_BITCNT] && header_checks_q[CHK_COMPR]
			&& header_checks_q[CHK_IMGSZ]
			&& (width_seen_q != 32'd0) && !width_seen_q[31]
			&& (height_seen_q != 32'd0) && !height_seen_q[31];
		result.image_width      = width_seen_q;
		result.image_height     = height_seen_q;
		result.row_bytes        = (width_x3 + 32'd3) & ~32'd3;
		result.file_size        = size_seen_q;
	end

endmodule
`default_nettype wire

// File: src/bhp_out_stage.sv
// Result register of the BMP header parser: holds one result until its transfer.
// Depends on bhp_pkg and bhp_out_if.
`default_nettype none
module bhp_out_stage
	import bhp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire flow_t     flow,
	input  wire out_item_t result,
	output logic           out_free,
	bhp_out_if.source      out_ch
);

	logic      out_valid_s2;
	out_item_t out_item_s2;
	logic      load;

	assign out_free = !out_valid_s2 || out_ch.ready;
	assign load     = flow.advance && flow.produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_s2 <= result;
		end
	end

	assign out_ch.valid            = out_valid_s2;
	assign out_ch.header_valid     = out_item_s2.header_valid;
	assign out_ch.format_supported = out_item_s2.format_supported;
	assign out_ch.image_width      = out_item_s2.image_width;
	assign out_ch.image_height     = out_item_s2.image_height;
	assign out_ch.row_bytes        = out_item_s2.row_bytes;
	assign out_ch.file_size        = out_item_s2.file_size;

endmodule
`default_nettype wire

// File: src/bmp_header_parser.sv
// BMP header parser top level: input register, field capture and result register.
// A result enters the result register as header byte 53 leaves the input register.
// Throughput: one byte per cycle, but the last header byte waits while a result is untaken.
// Reset clears the byte offset, pass flags and captured fields; the next byte counts
// as offset 0. Depends on bhp_pkg, bhp_in_if, bhp_out_if and the bhp stage modules.
`default_nettype none
module bmp_header_parser
	import bhp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	bhp_in_if.sink    byte_stream,
	bhp_out_if.source result
);

	logic      item_valid_s1;
	in_item_t  item_s1;
	flow_t     flow;
	out_item_t header_result;
	logic      out_free;

	bhp_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (byte_stream),
		.flow          (flow),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	bhp_field_capture u_field_capture (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.out_free      (out_free),
		.flow          (flow),
		.result        (header_result)
	);

	bhp_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.flow     (flow),
		.result   (header_result),
		.out_free (out_free),
		.out_ch   (result)
	);

`ifndef SYNTHESIS
	// A held byte that cannot move on stays in the input register unchanged.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && !flow.advance |=> item_valid_s1 && $stable(item_s1))
		else $error("input register lost or changed a held byte");

	// A result appears only after the last header byte moved into the result register.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(flow.advance && flow.produce))
		else $error("result appeared without a completed header");

	// A waiting result is never overwritten by a new one.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !(flow.advance && flow.produce))
		else $error("result overwritten while stalled");

	// Bytes only advance when the input register holds one.
	a_advance_valid: assert property (@(posedge clk) disable iff (!arst_n)
		flow.advance |-> item_valid_s1)
		else $error("advance without a held byte");
`endif

endmodule
`default_nettype wire

// File: tb/tb_bmp_header_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for the BMP header parser: streams BMP headers and noise into
// the byte channel and checks every decoded header against an in-bench predictor.
// Depends on bhp_pkg, bhp_in_if, bhp_out_if and bmp_header_parser.
module tb_bmp_header_parser;
	import bhp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned PHASE_BYTES  = 80;
	localparam int unsigned PHASE_HDRS   = 2;
	localparam int unsigned IDLE_PCT  [4] = '{0, 54, 0, 37};
	localparam int unsigned STALL_PCT [4] = '{0, 0, 54, 37};

	// Header image in file order: byte i of the file is bits [8*i +: 8].
	typedef struct packed {
		logic [127:0] tail;
		logic [31:0]  imgsz;
		logic [31:0]  compr;
		logic [15:0]  bitcnt;
		logic [15:0]  planes;
		logic [31:0]  height;
		logic [31:0]  width;
		logic [31:0]  infosz;
		logic [31:0]  offbits;
		logic [31:0]  rsvd;
		logic [31:0]  fsize;
		logic [15:0]  type_id;
	} bmp_hdr_t;

	// Tracks the header being parsed and holds the decoded headers still to come out.
	class hdr_scoreboard;
		logic [POS_W-1:0] byte_pos;
		logic [31:0]      shift_reg;
		logic [CHK_N-1:0] pass_flags;
		logic [31:0]      width_q;
		logic [31:0]      height_q;
		logic [31:0]      size_q;
		out_item_t        pending_headers[$];
		int unsigned      bytes_used;
		int unsigned      bytes_ignored;
		int unsigned      headers_seen;
		int unsigned      headers_checked;
		int unsigned      valid_count;
		int unsigned      supported_count;
		int unsigned      mismatches;

		function new();
			byte_pos = '0;
			shift_reg = '0;
			pass_flags = '0;
			width_q = '0;
			height_q = '0;
			size_q = '0;
			bytes_used = 0;
			bytes_ignored = 0;
			headers_seen = 0;
			headers_checked = 0;
			valid_count = 0;
			supported_count = 0;
			mismatches = 0;
		endfunction

		// Advances the parse by one transferred byte and queues a header at its last byte.
		function void note_byte(input logic [7:0] b, input logic r);
			logic [POS_W-1:0] pos;
			logic [31:0]      w;
			logic [15:0]      h;
			out_item_t        res;
			if (r) begin
				pos = '0;
				pass_flags = '0;
			end else begin
				pos = byte_pos;
			end
			if (pos >= POS_DONE) begin
				byte_pos = POS_DONE;
				bytes_ignored++;
				return;
			end
			bytes_used++;
			shift_reg = {b, shift_reg[31:8]};
			w = shift_reg;
			h = shift_reg[31:16];
			case (pos)
				POS_TYPE:    pass_flags[CHK_TYPE] = (h == BMP_TYPE_ID);
				POS_FSIZE:   size_q = w;
				POS_OFFBITS: pass_flags[CHK_OFFBITS] = (w == BMP_OFFBITS);
				POS_INFOSZ:  pass_flags[CHK_INFOSZ] = (w == BMP_INFO_SIZE);
				POS_WIDTH:   width_q = w;
				POS_HEIGHT:  height_q = w;
				POS_PLANES:  pass_flags[CHK_PLANES] = (h == BMP_PLANES);
				POS_BITCNT:  pass_flags[CHK_BITCNT] = (h == BMP_BIT_COUNT);
				POS_COMPR:   pass_flags[CHK_COMPR] = (w == 32'd0);
				POS_IMGSZ:   pass_flags[CHK_IMGSZ] = (w != 32'd0);
				default: ;
			endcase
			byte_pos = pos + POS_W'(1);
			if (pos == POS_LAST) begin
				res.header_valid = pass_flags[CHK_TYPE] && pass_flags[CHK_OFFBITS];
				res.format_supported = pass_flags[CHK_INFOSZ] && pass_flags[CHK_PLANES]
					&& pass_flags[CHK_BITCNT] && pass_flags[CHK_COMPR]
					&& pass_flags[CHK_IMGSZ]
					&& ($signed(width_q) > 0) && ($signed(height_q) > 0);
				res.image_width = width_q;
				res.image_height = height_q;
				res.row_bytes = (width_q * 32'd3 + 32'd3) & ~32'd3;
				res.file_size = size_q;
				pending_headers.push_back(res);
				headers_seen++;
				if (res.header_valid)
					valid_count++;
				if (res.format_supported)
					supported_count++;
			end
		endfunction

		task report(input string what, input logic [31:0] got, input logic [31:0] want);
			$display("ERROR header %0d %s: got %h, expected %h", headers_checked, what, got,
				want);
			mismatches++;
		endtask

		// Compares one decoded header with the oldest one predicted.
		task check_header(input out_item_t got);
			out_item_t want;
			if (pending_headers.size() == 0) begin
				report("result with no header pending", got.file_size, 32'd0);
				return;
			end
			want = pending_headers.pop_front();
			headers_checked++;
			if (got.header_valid !== want.header_valid)
				report("header_valid", 32'(got.header_valid), 32'(want.header_valid));
			if (got.format_supported !== want.format_supported)
				report("format_supported", 32'(got.format_supported),
					32'(want.format_supported));
			if (got.image_width !== want.image_width)
				report("image_width", got.image_width, want.image_width);
			if (got.image_height !== want.image_height)
				report("image_height", got.image_height, want.image_height);
			if (got.row_bytes !== want.row_bytes)
				report("row_bytes", got.row_bytes, want.row_bytes);
			if (got.file_size !== want.file_size)
				report("file_size", got.file_size, want.file_size);
		endtask
	endclass

	logic          clk;
	logic          arst_n;
	bhp_in_if      in_ch ();
	bhp_out_if     out_ch ();
	hdr_scoreboard sb;
	int unsigned   send_idle_pct;
	int unsigned   stall_pct;
	int unsigned   cycle_count;
	int unsigned   hold_left;
	bit            hold_request;

	bmp_header_parser u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (in_ch),
		.result      (out_ch)
	);

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off counted here when requested.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Every result transfer is checked against the predicted headers.
	always @(posedge clk) begin : result_monitor
		out_item_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.header_valid = out_ch.header_valid;
			got.format_supported = out_ch.format_supported;
			got.image_width = out_ch.image_width;
			got.image_height = out_ch.image_height;
			got.row_bytes = out_ch.row_bytes;
			got.file_size = out_ch.file_size;
			sb.check_header(got);
		end
	end

	// Offers one byte, with random idle cycles first, and waits for its transfer.
	task automatic send_byte(input logic [7:0] b, input logic r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.restart <= r;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_byte(b, r);
	endtask

	// Sends the first count bytes of a header; only the first may carry restart.
	task automatic send_header(input bmp_hdr_t h, input int unsigned count,
		input logic first_restart);
		logic [431:0] raw;
		raw = h;
		for (int unsigned i = 0; i < count; i++)
			send_byte(raw[8*i +: 8], (i == 0) ? first_restart : 1'b0);
	endtask

	// Stops offering and waits until every predicted header has come out.
	task automatic wait_results_drained();
		in_ch.valid <= 1'b0;
		while (sb.pending_headers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Width or height: mostly small positive, with zero, negative and extreme values.
	function automatic logic [31:0] random_dim();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return $urandom_range(1, 640);
			5:             return 32'd0;
			6:             return 32'd0 - 32'($urandom_range(1, 640));
			7: begin
				case ($urandom_range(2))
					0:       return 32'h7FFF_FFFF;
					1:       return 32'h8000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default:       return $urandom;
		endcase
	endfunction

	// A well-formed 24-bit header with random sizes and filler.
	function automatic bmp_hdr_t good_header();
		bmp_hdr_t h;
		h.type_id = BMP_TYPE_ID;
		h.fsize = $urandom;
		h.rsvd = $urandom;
		h.offbits = BMP_OFFBITS;
		h.infosz = BMP_INFO_SIZE;
		h.width = random_dim();
		h.height = random_dim();
		h.planes = BMP_PLANES;
		h.bitcnt = BMP_BIT_COUNT;
		h.compr = 32'd0;
		h.imgsz = $urandom;
		h.tail = {$urandom, $urandom, $urandom, $urandom};
		return h;
	endfunction

	// A header where each checked field is now and then spoiled.
	function automatic bmp_hdr_t random_header();
		bmp_hdr_t h;
		h = good_header();
		if ($urandom_range(7) == 0)
			h.type_id = 16'($urandom);
		if ($urandom_range(7) == 0)
			h.offbits = $urandom_range(1) ? $urandom : $urandom_range(0, 255);
		if ($urandom_range(7) == 0)
			h.infosz = $urandom_range(1) ? $urandom : $urandom_range(0, 255);
		if ($urandom_range(7) == 0)
			h.planes = 16'($urandom);
		if ($urandom_range(7) == 0)
			h.bitcnt = 16'($urandom_range(1) ? $urandom : $urandom_range(0, 32));
		if ($urandom_range(7) == 0)
			h.compr = $urandom_range(1) ? $urandom : $urandom_range(1, 6);
		if ($urandom_range(7) == 0)
			h.imgsz = 32'd0;
		return h;
	endfunction

	// One random stretch: mostly whole headers, some cut short, some loose bytes.
	task automatic send_random_burst();
		int unsigned kind;
		int unsigned n;
		bmp_hdr_t    h;
		kind = $urandom_range(99);
		h = random_header();
		if (kind < 75) begin
			send_header(h, HDR_LEN, $urandom_range(19) != 0);
			n = $urandom_range(6);
			repeat (n) send_byte(8'($urandom), 1'b0);
		end else if (kind < 88) begin
			send_header(h, $urandom_range(1, HDR_LEN - 1), 1'b1);
		end else begin
			n = $urandom_range(1, 10);
			repeat (n) send_byte(8'($urandom), $urandom_range(9) == 0);
		end
	endtask

	initial begin
		bmp_hdr_t    h;
		int unsigned bytes_mark;
		int unsigned hdr_mark;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'd0;
		in_ch.restart = 1'b0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		cycle_count = 0;
		hold_left = 0;
		hold_request = 1'b0;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First header after reset goes in without restart, then bytes past its end.
		h = good_header();
		h.width = 32'd3;
		h.height = 32'd2;
		send_header(h, HDR_LEN, 1'b0);
		repeat (3) send_byte(8'($urandom), 1'b0);

		// Smallest and largest positive sizes, then negative and zero ones.
		h = good_header();
		h.width = 32'd1;
		h.height = 32'd1;
		send_header(h, HDR_LEN, 1'b1);
		h.width = 32'h7FFF_FFFF;
		h.height = 32'h7FFF_FFFF;
		send_header(h, HDR_LEN, 1'b1);
		h.width = 32'h8000_0000;
		h.height = 32'hFFFF_FFFF;
		send_header(h, HDR_LEN, 1'b1);
		h.width = 32'd0;
		h.height = 32'd0;
		send_header(h, HDR_LEN, 1'b1);

		// Each checked field spoiled on its own.
		h = good_header();
		h.type_id = 16'h424D;
		send_header(h, HDR_LEN, 1'b1);
		h = good_header();
		h.offbits = 32'd138;
		send_header(h, HDR_LEN, 1'b1);
		h = good_header();
		h.infosz = 32'd124;
		send_header(h, HDR_LEN, 1'b1);
		h = good_header();
		h.planes = 16'd0;
		send_header(h, HDR_LEN, 1'b1);
		h = good_header();
		h.bitcnt = 16'd32;
		send_header(h, HDR_LEN, 1'b1);
		h = good_header();
		h.compr = 32'd1;
		send_header(h, HDR_LEN, 1'b1);
		h = good_header();
		h.imgsz = 32'd0;
		send_header(h, HDR_LEN, 1'b1);

		// Restart in the middle of a header, and a restart right after a restart.
		send_header(good_header(), 30, 1'b1);
		send_byte(8'($urandom), 1'b1);
		h = good_header();
		h.width = 32'hFFFF_FFFF;
		send_header(h, HDR_LEN, 1'b1);

		// All-ones and all-zero headers.
		h = '1;
		send_header(h, HDR_LEN, 1'b1);
		h = '0;
		send_header(h, HDR_LEN, 1'b1);
		wait_results_drained();

		// Random headers over four idling profiles; the first one opens with a long
		// result hold-off so the block backs up into its input.
		for (int unsigned ph = 0; ph < 4; ph++) begin
			send_idle_pct = IDLE_PCT[ph];
			stall_pct = STALL_PCT[ph];
			if (ph == 0)
				hold_request = 1'b1;
			bytes_mark = sb.bytes_used;
			hdr_mark = sb.headers_seen;
			while (sb.bytes_used - bytes_mark < PHASE_BYTES
				|| sb.headers_seen - hdr_mark < PHASE_HDRS)
				send_random_burst();
			// Keep offering bytes while the held-off results block the input.
			if (ph == 0)
				send_header(random_header(), HDR_LEN, 1'b1);
			wait_results_drained();
		end

		if (sb.pending_headers.size() != 0)
			sb.report("headers never reported", 32'(sb.pending_headers.size()), 32'd0);
		$display("Run covered %0d header bytes and %0d ignored bytes past header ends.",
			sb.bytes_used, sb.bytes_ignored);
		$display("Checked %0d of %0d headers: %0d with valid signature, %0d supported.",
			sb.headers_checked, sb.headers_seen, sb.valid_count, sb.supported_count);
		if (sb.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/bhp_pkg.sv
src/bhp_in_if.sv
src/bhp_out_if.sv
src/bhp_in_stage.sv
src/bhp_field_capture.sv
src/bhp_out_stage.sv
src/bmp_header_parser.sv
tb/tb_bmp_header_parser.sv
